[sv/silto_pkg.sv]
// Shared types and constants for the silence timeout detector.
`timescale 1ns / 1ps

package silto_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ELEMENT = 2'd1,
    OP_TICK    = 2'd2,
    OP_RESTART = 2'd3
  } opcode_t;

  typedef enum logic {
    CFG_LOUD_THRESHOLD = 1'b0,
    CFG_SILENCE_LIMIT  = 1'b1
  } cfg_index_t;

  localparam int DATA_W    = 16;
  localparam int MAG_W     = 17;  // |-32768| needs one more bit
  localparam int SQ_W      = 31;  // 32768^2 = 2^30
  localparam int T2_W      = 32;  // threshold register squared
  localparam int ELAPSED_W = 16;

  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 16'd328;
  localparam logic [DATA_W-1:0] LIMIT_RESET     = 16'd2000;
  localparam logic [T2_W-1:0]   T2_RESET        = 32'd107584;  // 328 * 328

  typedef struct packed {
    opcode_t          op;
    logic             last;
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  sq;
  } front_t;

  typedef struct packed {
    opcode_t op;
    logic    last;
    logic    loud;  // single-sample loudness
  } ctrl_t;

endpackage

[sv/silto_front.sv]
// Input register: captures a request and forms its magnitude and square.
`timescale 1ns / 1ps

module silto_front import silto_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     last,
  output front_t                   item,
  output logic                     item_valid,
  input  logic                     item_ready
);

  logic signed [MAG_W-1:0] s_ext;
  logic [MAG_W-1:0]        mag;
  logic [2*MAG_W-1:0]      sq_full;

  assign s_ext    = {sample[DATA_W-1], sample};
  assign mag      = sample[DATA_W-1] ? MAG_W'(-s_ext) : MAG_W'(s_ext);
  assign sq_full  = mag * mag;
  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item.op   <= opcode_t'(opcode);
      item.last <= last;
      item.mag  <= mag;
      item.sq   <= sq_full[SQ_W-1:0];
    end
  end

endmodule

[sv/silto_accum.sv]
// Buffer accumulator: running sum of squares and element count.
`timescale 1ns / 1ps

module silto_accum import silto_pkg::*; #(
  parameter int MAX_BUFFER_LEN = 4096,
  parameter int CNT_W          = $clog2(MAX_BUFFER_LEN + 1),
  parameter int SUM_W          = SQ_W - 1 + CNT_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] threshold,
  input  front_t            item,
  input  logic              item_valid,
  output logic              item_ready,
  output ctrl_t             ctrl,
  output logic [SUM_W-1:0]  sum_out,
  output logic [CNT_W-1:0]  cnt_out,
  output logic              out_valid,
  input  logic              out_ready
);

  logic [SUM_W-1:0] sum, sum_acc, sum_next;
  logic [CNT_W-1:0] cnt, cnt_acc, cnt_next;
  logic             room;
  logic             go;

  assign item_ready = !out_valid || out_ready;
  assign go         = item_valid && item_ready;

  // past the buffer limit, elements are dropped but last still closes it
  assign room    = cnt < CNT_W'(MAX_BUFFER_LEN);
  assign sum_acc = room ? sum + SUM_W'(item.sq) : sum;
  assign cnt_acc = room ? cnt + CNT_W'(1) : cnt;

  always_comb begin
    sum_next = sum;
    cnt_next = cnt;
    unique case (item.op) inside
      OP_ELEMENT: begin
        if (item.last) begin
          sum_next = '0;
          cnt_next = '0;
        end else begin
          sum_next = sum_acc;
          cnt_next = cnt_acc;
        end
      end
      OP_RESTART: begin
        sum_next = '0;
        cnt_next = '0;
      end
      OP_SAMPLE, OP_TICK: begin
        sum_next = sum;
        cnt_next = cnt;
      end
      default: begin
        sum_next = sum;
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        out_valid <= item_valid;
      end
      if (go) begin
        sum <= sum_next;
        cnt <= cnt_next;
      end
    end
    if (go) begin
      ctrl.op   <= item.op;
      ctrl.last <= item.last;
      ctrl.loud <= item.mag >= MAG_W'(threshold);
      sum_out   <= sum_acc;
      cnt_out   <= cnt_acc;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_BUFFER_LEN))
    else $error("element count above buffer limit");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    go && item.op == OP_RESTART |=> cnt == '0 && sum == '0)
    else $error("restart left a partial buffer");

endmodule

[sv/silto_mult.sv]
// Product stage: squared threshold times element count for the buffer compare.
`timescale 1ns / 1ps

module silto_mult import silto_pkg::*; #(
  parameter int CNT_W = 13,
  parameter int SUM_W = SQ_W - 1 + CNT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [T2_W-1:0]  t2,
  input  ctrl_t            ctrl_in,
  input  logic [SUM_W-1:0] sum_in,
  input  logic [CNT_W-1:0] cnt_in,
  input  logic             in_valid,
  output logic             in_ready,
  output ctrl_t            ctrl_out,
  output logic [SUM_W-1:0] sum_out,
  output logic [T2_W+CNT_W-1:0] prod_out,
  output logic             out_valid,
  input  logic             out_ready
);

  localparam int PROD_W = T2_W + CNT_W;

  logic go;

  assign in_ready = !out_valid || out_ready;
  assign go       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (go) begin
      ctrl_out <= ctrl_in;
      sum_out  <= sum_in;
      prod_out <= PROD_W'(t2) * PROD_W'(cnt_in);
    end
  end

endmodule

[sv/silto_decide.sv]
// Decision stage: loud/quiet flags, elapsed time, one-shot timeout, result register.
`timescale 1ns / 1ps

module silto_decide import silto_pkg::*; #(
  parameter int SUM_W  = 43,
  parameter int PROD_W = 45
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DATA_W-1:0]    limit,
  input  ctrl_t                ctrl,
  input  logic [SUM_W-1:0]     sum,
  input  logic [PROD_W-1:0]    prod,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 silent,
  output logic                 timeout_pulse,
  output logic                 timed_out,
  output logic [ELAPSED_W-1:0] silence_ms,
  output logic                 out_valid,
  input  logic                 out_ready
);

  logic [ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next;
  logic                 silent_flag, silent_flag_next;
  logic                 fired_flag, fired_flag_next;
  logic                 pulse;
  logic                 decision;
  logic                 loud;
  logic                 go;

  assign in_ready = !out_valid || out_ready;
  assign go       = in_valid && in_ready;

  assign decision = ctrl.op == OP_SAMPLE || (ctrl.op == OP_ELEMENT && ctrl.last);
  // buffer: sum of squares against threshold^2 * count, exact
  assign loud     = (ctrl.op == OP_SAMPLE) ? ctrl.loud : (PROD_W'(sum) >= prod);

  always_comb begin
    elapsed_ms_next  = elapsed_ms;
    silent_flag_next = silent_flag;
    fired_flag_next  = fired_flag;
    pulse            = 1'b0;
    unique case (ctrl.op) inside
      OP_SAMPLE, OP_ELEMENT: begin
        if (decision) begin
          if (loud) begin
            elapsed_ms_next  = '0;
            silent_flag_next = 1'b0;
            fired_flag_next  = 1'b0;
          end else begin
            silent_flag_next = 1'b1;
            if (!fired_flag && elapsed_ms >= limit) begin
              fired_flag_next = 1'b1;
              pulse           = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (elapsed_ms != '1) begin
          elapsed_ms_next = elapsed_ms + ELAPSED_W'(1);
        end
      end
      OP_RESTART: begin
        elapsed_ms_next  = '0;
        silent_flag_next = 1'b0;
        fired_flag_next  = 1'b0;
      end
      default: begin
        elapsed_ms_next = elapsed_ms;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms  <= '0;
      silent_flag <= 1'b0;
      fired_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (go) begin
        elapsed_ms  <= elapsed_ms_next;
        silent_flag <= silent_flag_next;
        fired_flag  <= fired_flag_next;
      end
    end
    if (go) begin
      silent        <= silent_flag_next;
      timeout_pulse <= pulse;
      timed_out     <= fired_flag_next;
      silence_ms    <= elapsed_ms_next;
    end
  end

  a_pulse_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout_pulse |-> timed_out && silent)
    else $error("timeout pulse without sticky and silent flags");

  a_fired_silent: assert property (@(posedge clk) disable iff (rst)
    fired_flag |-> silent_flag)
    else $error("fired flag set while not silent");

  a_loud_clears: assert property (@(posedge clk) disable iff (rst)
    go && decision && loud |=> elapsed_ms == '0 && !fired_flag && !silent_flag)
    else $error("loud decision did not clear state");

endmodule

[sv/silence_timeout_detector_top.sv]
// Silence timeout detector: top level with configuration registers.
//
// Requests enter on in_valid/in_ready carrying opcode, sample and last:
// single sample, buffer element, millisecond tick or restart. Every request
// yields exactly one result on out_valid/out_ready: silent, timeout_pulse,
// timed_out and silence_ms as they stand after that request.
// Throughput is one request per cycle while out_ready is high. Each
// request passes through four registers in a row: input register with
// the sample square, buffer accumulator, threshold-product multiplier
// (squared threshold times element count), decision register.
// If the receiver holds out_ready low, the four registers fill and
// in_ready falls; nothing is dropped and work resumes as soon as the
// result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the squared threshold is formed at the write. Write only when no request
// is in flight.
// Reset (rst, synchronous) empties the pipeline, clears all flags, the
// elapsed count and any partial buffer, and restores threshold 328 and
// limit 2000 ms.
`timescale 1ns / 1ps

module silence_timeout_detector_top import silto_pkg::*; #(
  parameter int MAX_BUFFER_LEN = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     silent,
  output logic                     timeout_pulse,
  output logic                     timed_out,
  output logic [ELAPSED_W-1:0]     silence_ms
);

  localparam int CNT_W  = $clog2(MAX_BUFFER_LEN + 1);
  localparam int SUM_W  = SQ_W - 1 + CNT_W;
  localparam int PROD_W = T2_W + CNT_W;

  logic [DATA_W-1:0] threshold;
  logic [DATA_W-1:0] limit;
  logic [T2_W-1:0]   t2;

  front_t            f_item;
  logic              f_valid, f_ready;
  ctrl_t             a_ctrl;
  logic [SUM_W-1:0]  a_sum;
  logic [CNT_W-1:0]  a_cnt;
  logic              a_valid, a_ready;
  ctrl_t             m_ctrl;
  logic [SUM_W-1:0]  m_sum;
  logic [PROD_W-1:0] m_prod;
  logic              m_valid, m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      limit     <= LIMIT_RESET;
      t2        <= T2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LOUD_THRESHOLD: begin
          threshold <= cfg_data;
          t2        <= T2_W'(cfg_data) * T2_W'(cfg_data);
        end
        CFG_SILENCE_LIMIT: begin
          limit <= cfg_data;
        end
        default: begin
          limit <= limit;
        end
      endcase
    end
  end

  silto_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .sample     (sample),
    .last       (last),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  silto_accum #(
    .MAX_BUFFER_LEN (MAX_BUFFER_LEN),
    .CNT_W          (CNT_W),
    .SUM_W          (SUM_W)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .threshold  (threshold),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .ctrl       (a_ctrl),
    .sum_out    (a_sum),
    .cnt_out    (a_cnt),
    .out_valid  (a_valid),
    .out_ready  (a_ready)
  );

  silto_mult #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_mult (
    .clk       (clk),
    .rst       (rst),
    .t2        (t2),
    .ctrl_in   (a_ctrl),
    .sum_in    (a_sum),
    .cnt_in    (a_cnt),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .ctrl_out  (m_ctrl),
    .sum_out   (m_sum),
    .prod_out  (m_prod),
    .out_valid (m_valid),
    .out_ready (m_ready)
  );

  silto_decide #(
    .SUM_W  (SUM_W),
    .PROD_W (PROD_W)
  ) u_decide (
    .clk           (clk),
    .rst           (rst),
    .limit         (limit),
    .ctrl          (m_ctrl),
    .sum           (m_sum),
    .prod          (m_prod),
    .in_valid      (m_valid),
    .in_ready      (m_ready),
    .silent        (silent),
    .timeout_pulse (timeout_pulse),
    .timed_out     (timed_out),
    .silence_ms    (silence_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule
